// File: rtl/sem_pkg.sv
// Shared types and codes for the Sobel edge magnitude block.
// Used by every module under rtl/ except sem_ram; no dependencies of its own.
package sem_pkg;

    localparam int PIX_W     = 8;   // luminance and color component width
    localparam int CFG_DIM_W = 11;  // image_width / image_height register width
    localparam int SENS_W    = 16;  // sensitivity register width
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_SENSITIVITY  = 2'd2
    } t_cfg_index;

    // item kinds
    localparam logic ITEM_PIXEL = 1'b0;
    localparam logic ITEM_DRAIN = 1'b1;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
        logic [SENS_W-1:0]    sensitivity;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_end;
    } t_out_item;

    // 3x3 luminance window, cell (r,c) at index r*3+c
    typedef logic [8:0][PIX_W-1:0] t_window;

    // one pending result, handed from the front to the back
    typedef struct packed {
        t_window window;
        logic    border;
        logic    last;
    } t_task;

    typedef enum logic {
        F_IDLE,
        F_WORK
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GRAD,
        B_SQUARE,
        B_SCALE1,
        B_SCALE2,
        B_ROOT,
        B_DONE
    } t_back_state;

endpackage

// File: rtl/sem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/sem_front.sv
// Front end: takes items, converts to luminance, keeps the line stores and
// the 3x3 window, tracks raster position and queues one task per result.
// Depends on sem_pkg and sem_ram.
module sem_front import sem_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_task    o_q_task
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int WW     = (XW + 1 > CFG_DIM_W) ? XW + 1 : CFG_DIM_W;
    localparam int HW     = (YW + 1 > CFG_DIM_W) ? YW + 1 : CFG_DIM_W;
    localparam int LUMA_W = 24;

    localparam logic [LUMA_W-1:0] COEF_R = 24'd19595;
    localparam logic [LUMA_W-1:0] COEF_G = 24'd38470;
    localparam logic [LUMA_W-1:0] COEF_B = 24'd7471;

    t_front_state r_state, n_state;
    logic         accept;

    t_in_item         r_item;
    logic [XW-1:0]    r_in_col, n_in_col;
    logic [YW-1:0]    r_in_row, n_in_row;
    logic [XW-1:0]    r_out_col, n_out_col;
    logic [YW-1:0]    r_out_row, n_out_row;
    logic             r_done, n_done;
    t_window          r_window, n_window;

    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] ram_wdata;
    logic               ram_we;

    logic [WW-1:0]     w_clip;
    logic [HW-1:0]     h_clip;
    logic [XW-1:0]     w_last;
    logic [YW-1:0]     h_last;
    logic [LUMA_W-1:0] luma_sum;
    logic [PIX_W-1:0]  luma, top, mid;
    logic              work, pixel, trigger, emit;
    logic              in_last_col, in_last_row;
    logic              out_last_col, out_last_row, border, last;

    // effective frame size, 0 counts as 1, clipped to the line store size
    always_comb begin
        w_clip = WW'(i_cfg.image_width);
        if (w_clip == '0) begin
            w_clip = WW'(1);
        end else if (w_clip > WW'(MAX_WIDTH)) begin
            w_clip = WW'(MAX_WIDTH);
        end
        h_clip = HW'(i_cfg.image_height);
        if (h_clip == '0) begin
            h_clip = HW'(1);
        end else if (h_clip > HW'(MAX_HEIGHT)) begin
            h_clip = HW'(MAX_HEIGHT);
        end
        w_last = XW'(w_clip - WW'(1));
        h_last = YW'(h_clip - HW'(1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_WORK;
            F_WORK:  n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_full = (r_state != F_IDLE) || i_q_full;
        work   = (r_state == F_WORK);
    end

    assign accept = i_push && !o_full;

    // line stores: one word holds {upper, middle} for a column
    sem_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_in_col),
        .i_wdata (ram_wdata),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    // luminance, truncated
    always_comb begin
        luma_sum = COEF_R * LUMA_W'(r_item.red)
                 + COEF_G * LUMA_W'(r_item.green)
                 + COEF_B * LUMA_W'(r_item.blue);
        luma     = luma_sum[LUMA_W-1 -: PIX_W];
    end

    // rows not yet filled in this frame read as zero
    assign top = (r_in_row >= YW'(2)) ? ram_rdata[2*PIX_W-1:PIX_W] : '0;
    assign mid = (r_in_row >= YW'(1)) ? ram_rdata[PIX_W-1:0] : '0;

    assign pixel   = work && !r_done && (r_item.kind == ITEM_PIXEL);
    assign trigger = (r_in_row >= YW'(2)) || ((r_in_row == YW'(1)) && (r_in_col != '0));
    assign emit    = work && (r_done || (pixel && trigger));

    assign ram_we    = pixel;
    assign ram_wdata = {mid, luma};

    assign in_last_col  = (r_in_col >= w_last);
    assign in_last_row  = (r_in_row >= h_last);
    assign out_last_col = (r_out_col >= w_last);
    assign out_last_row = (r_out_row >= h_last);
    assign border = (r_out_row == '0) || (r_out_col == '0) || out_last_row || out_last_col;
    assign last   = out_last_row && out_last_col;

    // window shift and position counters
    always_comb begin
        n_window  = r_window;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_done    = r_done;
        if (pixel) begin
            n_window[0] = r_window[1];
            n_window[1] = r_window[2];
            n_window[3] = r_window[4];
            n_window[4] = r_window[5];
            n_window[6] = r_window[7];
            n_window[7] = r_window[8];
            n_window[2] = top;
            n_window[5] = mid;
            n_window[8] = luma;
            if (in_last_row && in_last_col) begin
                n_done = 1'b1;
            end else if (in_last_col) begin
                n_in_col = '0;
                n_in_row = r_in_row + YW'(1);
            end else begin
                n_in_col = r_in_col + XW'(1);
            end
        end
        if (emit) begin
            if (last) begin
                // frame complete: rewind position counters and done flag
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_done    = 1'b0;
            end else if (out_last_col) begin
                n_out_col = '0;
                n_out_row = r_out_row + YW'(1);
            end else begin
                n_out_col = r_out_col + XW'(1);
            end
        end
    end

    // task toward the back end
    always_comb begin
        o_q_push        = emit;
        o_q_task.window = n_window;
        o_q_task.border = border;
        o_q_task.last   = last;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_done    <= 1'b0;
            r_window  <= '0;
        end else begin
            r_state   <= n_state;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_done    <= n_done;
            r_window  <= n_window;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/sem_queue.sv
// Short task queue between the front and the back end.
// Depends on sem_pkg.
module sem_queue import sem_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_task o_head
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_task         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + AW'(1);
            if (do_pop)  r_rp <= r_rp + AW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

endmodule

// File: rtl/sem_back.sv
// Back end: Sobel gradients, squared magnitude, gain and an iterative
// square root, then the result register. Depends on sem_pkg.
module sem_back import sem_pkg::*; #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SENS_W-1:0] i_sensitivity,
    input  logic              i_q_empty,
    input  t_task             i_q_head,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output t_out_item         o_result
);

    localparam int GRAD_W = PIX_W + 2;              // |gx|, |gy| up to 1020
    localparam int MAG_W  = 2 * GRAD_W + 1;         // gx^2 + gy^2
    localparam int MS_W   = MAG_W + SENS_W;
    localparam int X_W    = MS_W + SENS_W;
    localparam int Z_W    = X_W - 2 * GAIN_FRAC_BITS;
    localparam int RAD_W  = 2 * PIX_W;              // radicand below saturation
    localparam logic [RAD_W-1:0] ROOT_BIT_INIT = RAD_W'(1) << (RAD_W - 2);

    t_back_state r_state, n_state;

    t_task             r_task;
    logic [GRAD_W-1:0] r_ax, r_ay;
    logic [MAG_W-1:0]  r_m;
    logic [MS_W-1:0]   r_ms;
    logic [RAD_W-1:0]  r_rem, r_root, r_bit;
    logic              r_sat;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y;
    logic [X_W-1:0]    x_full;
    logic [Z_W-1:0]    z;
    logic [RAD_W:0]    trial;
    logic              fits;
    logic              out_load;
    logic [PIX_W-1:0]  value;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:   if (!i_q_empty) n_state = B_GRAD;
            B_GRAD:   n_state = B_SQUARE;
            B_SQUARE: n_state = B_SCALE1;
            B_SCALE1: n_state = B_SCALE2;
            B_SCALE2: n_state = B_ROOT;
            B_ROOT:   if (r_bit == RAD_W'(1)) n_state = B_DONE;
            B_DONE:   if (!r_out_valid || i_pop) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
        out_load = (r_state == B_DONE) && (!r_out_valid || i_pop);
    end

    // gradient sums; cell (r,c) is window[r*3+c]
    always_comb begin
        pos_x = GRAD_W'(r_task.window[2]) + GRAD_W'({r_task.window[5], 1'b0})
              + GRAD_W'(r_task.window[8]);
        neg_x = GRAD_W'(r_task.window[0]) + GRAD_W'({r_task.window[3], 1'b0})
              + GRAD_W'(r_task.window[6]);
        pos_y = GRAD_W'(r_task.window[6]) + GRAD_W'({r_task.window[7], 1'b0})
              + GRAD_W'(r_task.window[8]);
        neg_y = GRAD_W'(r_task.window[0]) + GRAD_W'({r_task.window[1], 1'b0})
              + GRAD_W'(r_task.window[2]);
    end

    // second gain multiply, then drop 2*frac bits (floor of root commutes)
    assign x_full = r_ms * X_W'(i_sensitivity);
    assign z      = x_full[X_W-1:2*GAIN_FRAC_BITS];

    // one restoring square-root step
    assign trial = {1'b0, r_root} + {1'b0, r_bit};
    assign fits  = ({1'b0, r_rem} >= trial);

    always_comb begin
        if (r_task.border) begin
            value = '0;
        end else if (r_sat) begin
            value = '1;
        end else begin
            value = r_root[PIX_W-1:0];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) r_task <= i_q_head;
            end
            B_GRAD: begin
                r_ax <= (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
                r_ay <= (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
            end
            B_SQUARE: begin
                r_m <= MAG_W'(r_ax * r_ax) + MAG_W'(r_ay * r_ay);
            end
            B_SCALE1: begin
                r_ms <= r_m * MS_W'(i_sensitivity);
            end
            B_SCALE2: begin
                r_rem  <= z[RAD_W-1:0];
                r_sat  <= |z[Z_W-1:RAD_W];
                r_root <= '0;
                r_bit  <= ROOT_BIT_INIT;
            end
            B_ROOT: begin
                if (fits) begin
                    r_rem  <= r_rem - trial[RAD_W-1:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.edge_value <= value;
            r_out.frame_end  <= r_task.last;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// File: rtl/sobel_edge_magnitude.sv
// Sobel edge magnitude over a raster RGB stream: configuration registers
// and the front / queue / back pipeline.
// Depends on sem_pkg, sem_front, sem_queue, sem_back.
//
// Usage:
//   Input is a queue write port: an item transfers when push is high and
//   full is low. kind selects a pixel or a drain tick; send width*height
//   pixels, then width+1 drain ticks to flush the frame tail.
//   Results come out of a queue read port: the oldest result sits on
//   o_result while empty is low and transfers when pop is high. frame_end
//   marks the last result of a frame; every counter then rewinds.
//   The front takes one item at a time: it reads the line store, then
//   writes it back, and stays full meanwhile. The back works on one task
//   at a time, its pace set by the gain multiplier chain and the 8-step
//   square-root unit, and takes no new task until its result is loaded.
//   A 4-entry task queue sits between the two; when the receiver stalls,
//   the result register holds, the queue fills and full rises.
//   Reset clears counters, window and queue and loads image_width 640,
//   image_height 480, sensitivity 256. Line stores are not cleared; rows
//   are masked until written. Configure only while the block is idle.
module sobel_edge_magnitude import sem_pkg::*; #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  t_in_item             i_item,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SENS_W-1:0]    i_cfg_data
);

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [SENS_W-1:0]    SENS_RESET   = 16'd256;

    t_cfg  r_cfg;
    logic  q_push, q_full, q_pop, q_empty;
    t_task q_task, q_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= WIDTH_RESET;
            r_cfg.image_height <= HEIGHT_RESET;
            r_cfg.sensitivity  <= SENS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_SENSITIVITY:  r_cfg.sensitivity  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_task (q_task)
    );

    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_task  (q_task),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    sem_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sensitivity (r_cfg.sensitivity),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_result      (o_result)
    );

endmodule

// File: rtl/sem_checker.sv
// Port-level checks for sobel_edge_magnitude, bound to the top level.
// Depends on sem_pkg.
module sem_checker import sem_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending right after reset");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed or vanished");

    // the front is busy in the cycle after a transfer
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("input taken on consecutive cycles");

    // the last result of a frame is a border pixel
    a_last_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.frame_end) |-> (o_result.edge_value == '0))
        else $error("frame end result is not zero");

endmodule

bind sobel_edge_magnitude sem_checker u_checker (.*);
